FILE: rtl/midpoint_line_rasterizer_unit_assert.svh
// Assertion macros shared by the midpoint line rasterizer RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef MIDPOINT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MLR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("midpoint line rasterizer assertion failed");
`define MLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("midpoint line rasterizer assertion failed");
`else
`define MLR_ASSERT_NOW(lbl, ante, cons)
`define MLR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
// No dependencies.
`default_nettype none
package mlr_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NEXT = 1'b1
  } op_t;

  localparam int COLOR_BITS = 8;

endpackage
`default_nettype wire

FILE: rtl/mlr_front.sv
// Front end: classifies incoming words and prepares line setup for the queue.
// Depends on mlr_pkg.
`default_nettype none
module mlr_front #(
  parameter int COORD_BITS = 12,
  parameter int IN_W       = 56,
  parameter int ENTRY_W    = 71
) (
  input  wire logic [IN_W-1:0]    in_tdata,
  input  wire logic               in_tuser,
  output logic      [ENTRY_W-1:0] entry
);
  import mlr_pkg::*;

  localparam int C = COORD_BITS;

  logic [C-1:0]          s_row, s_col, e_row, e_col;
  logic [COLOR_BITS-1:0] color;
  logic [C:0]            dr, dc, adr_full, adc_full, minor, dmin;
  logic [C-1:0]          adr, adc, dmaj, r0, c0, major_end;
  logic                  row_major, swap;
  op_t                   op;

  always_comb begin
    s_row = in_tdata[C-1:0];
    s_col = in_tdata[2*C-1:C];
    e_row = in_tdata[3*C-1:2*C];
    e_col = in_tdata[4*C-1:3*C];
    color = in_tdata[4*C+COLOR_BITS-1:4*C];
    op    = op_t'(in_tuser);

    dr = {1'b0, e_row} - {1'b0, s_row};
    dc = {1'b0, e_col} - {1'b0, s_col};
    adr_full = dr[C] ? (~dr + 1'b1) : dr;
    adc_full = dc[C] ? (~dc + 1'b1) : dc;
    adr = adr_full[C-1:0];
    adc = adc_full[C-1:0];

    row_major = adr > adc;
    swap      = row_major ? dr[C] : dc[C];

    r0 = swap ? e_row : s_row;
    c0 = swap ? e_col : s_col;
    if (row_major) begin
      major_end = swap ? s_row : e_row;
      dmaj      = adr;
      minor     = dc;
    end else begin
      major_end = swap ? s_col : e_col;
      dmaj      = adc;
      minor     = dr;
    end
    dmin = swap ? (~minor + 1'b1) : minor;

    entry = ENTRY_W'({color, row_major, dmin, dmaj, major_end, c0, r0, op});
  end

endmodule
`default_nettype wire

FILE: rtl/mlr_fifo.sv
// Small register queue that decouples the front end from the stepping engine.
// No package dependencies; uses the shared assertion macros.
`default_nettype none
`include "midpoint_line_rasterizer_unit_assert.svh"
module mlr_fifo #(
  parameter int WIDTH = 71,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic                  pop_valid,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  always_comb begin
    push_ready = cnt_r != CNT_W'(DEPTH);
    pop_valid  = cnt_r != '0;
    pop_data   = slots_r[rd_ptr_r];
    do_push    = push && push_ready;
    do_pop     = pop && pop_valid;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  `MLR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `MLR_ASSERT_NEXT(a_cnt_track, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule
`default_nettype wire

FILE: rtl/mlr_back.sv
// Stepping engine: loads line setup, steps the decision value, drives the
// output register. Depends on mlr_pkg and the shared assertion macros.
`default_nettype none
`include "midpoint_line_rasterizer_unit_assert.svh"
module mlr_back #(
  parameter int COORD_BITS = 12,
  parameter int ENTRY_W    = 71,
  parameter int OUT_W      = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire logic [ENTRY_W-1:0] q_data,
  output logic                    q_pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [OUT_W-1:0]   out_tdata,
  output logic                    out_tlast
);
  import mlr_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = COORD_BITS + 5;

  op_t                   h_op;
  logic [C-1:0]          h_r0, h_c0, h_end, h_dmaj;
  logic [C:0]            h_dmin;
  logic                  h_row_major;
  logic [COLOR_BITS-1:0] h_color;
  logic [DW-1:0]         dmin_x, dmaj_x, dmin2;

  logic [C-1:0]          cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [C-1:0]          major_end_r, major_end_nxt;
  logic [DW-1:0]         decision_r, decision_nxt;
  logic [DW-1:0]         step_straight_r, step_straight_nxt;
  logic [DW-1:0]         step_diag_up_r, step_diag_up_nxt;
  logic [DW-1:0]         step_diag_down_r, step_diag_down_nxt;
  logic                  row_major_r, row_major_nxt;
  logic                  slope_negative_r, slope_negative_nxt;
  logic [COLOR_BITS-1:0] line_color_r, line_color_nxt;
  logic                  busy_r, busy_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [C-1:0]          out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [COLOR_BITS-1:0] out_color_r, out_color_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  can_emit, emit, is_last, dec_le0, minor_up, minor_dn;
  logic [C-1:0]          minor_cur, minor_next;

  always_comb begin
    h_op        = op_t'(q_data[0]);
    h_r0        = q_data[C:1];
    h_c0        = q_data[2*C:C+1];
    h_end       = q_data[3*C:2*C+1];
    h_dmaj      = q_data[4*C:3*C+1];
    h_dmin      = q_data[5*C+1:4*C+1];
    h_row_major = q_data[5*C+2];
    h_color     = q_data[5*C+2+COLOR_BITS:5*C+3];

    dmin_x = {{(DW-C-1){h_dmin[C]}}, h_dmin};
    dmaj_x = {{(DW-C){1'b0}}, h_dmaj};
    dmin2  = {dmin_x[DW-2:0], 1'b0};

    can_emit = !out_valid_r || out_tready;
    q_pop    = q_valid && (h_op == OP_LOAD || can_emit);
    emit     = q_pop && h_op == OP_NEXT && busy_r;
    is_last  = (row_major_r ? cur_row_r : cur_col_r) == major_end_r;

    dec_le0  = decision_r[DW-1] || decision_r == '0;
    minor_up = !slope_negative_r && !dec_le0;
    minor_dn = slope_negative_r && dec_le0;
    minor_cur = row_major_r ? cur_col_r : cur_row_r;
    if (minor_up) begin
      minor_next = minor_cur + 1'b1;
    end else if (minor_dn) begin
      minor_next = minor_cur - 1'b1;
    end else begin
      minor_next = minor_cur;
    end

    cur_row_nxt        = cur_row_r;
    cur_col_nxt        = cur_col_r;
    major_end_nxt      = major_end_r;
    decision_nxt       = decision_r;
    step_straight_nxt  = step_straight_r;
    step_diag_up_nxt   = step_diag_up_r;
    step_diag_down_nxt = step_diag_down_r;
    row_major_nxt      = row_major_r;
    slope_negative_nxt = slope_negative_r;
    line_color_nxt     = line_color_r;
    busy_nxt           = busy_r;

    out_valid_nxt = out_valid_r && !out_tready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;

    if (q_pop && h_op == OP_LOAD) begin
      cur_row_nxt        = h_r0;
      cur_col_nxt        = h_c0;
      major_end_nxt      = h_end;
      slope_negative_nxt = h_dmin[C];
      decision_nxt       = h_dmin[C] ? dmin2 + dmaj_x : dmin2 - dmaj_x;
      step_straight_nxt  = dmin2;
      step_diag_up_nxt   = {dmin_x[DW-2:0] - dmaj_x[DW-2:0], 1'b0};
      step_diag_down_nxt = {dmin_x[DW-2:0] + dmaj_x[DW-2:0], 1'b0};
      row_major_nxt      = h_row_major;
      line_color_nxt     = h_color;
      busy_nxt           = 1'b1;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = cur_row_r;
      out_col_nxt   = cur_col_r;
      out_color_nxt = line_color_r;
      out_last_nxt  = is_last;
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        if (minor_up) begin
          decision_nxt = decision_r + step_diag_up_r;
        end else if (minor_dn) begin
          decision_nxt = decision_r + step_diag_down_r;
        end else begin
          decision_nxt = decision_r + step_straight_r;
        end
        if (row_major_r) begin
          cur_row_nxt = cur_row_r + 1'b1;
          cur_col_nxt = minor_next;
        end else begin
          cur_col_nxt = cur_col_r + 1'b1;
          cur_row_nxt = minor_next;
        end
      end
    end

    out_tvalid = out_valid_r;
    out_tdata  = OUT_W'({out_color_r, out_col_r, out_row_r});
    out_tlast  = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r        <= cur_row_nxt;
    cur_col_r        <= cur_col_nxt;
    major_end_r      <= major_end_nxt;
    decision_r       <= decision_nxt;
    step_straight_r  <= step_straight_nxt;
    step_diag_up_r   <= step_diag_up_nxt;
    step_diag_down_r <= step_diag_down_nxt;
    row_major_r      <= row_major_nxt;
    slope_negative_r <= slope_negative_nxt;
    line_color_r     <= line_color_nxt;
    out_row_r        <= out_row_nxt;
    out_col_r        <= out_col_nxt;
    out_color_r      <= out_color_nxt;
    out_last_r       <= out_last_nxt;
  end

  `MLR_ASSERT_NEXT(a_last_idles, emit && is_last, !busy_r && out_valid_r && out_last_r)
  `MLR_ASSERT_NOW(a_emit_needs_busy, $rose(out_valid_r), $past(busy_r))

endmodule
`default_nettype wire

FILE: rtl/midpoint_line_rasterizer_unit.sv
// A next word enters a queue slot; the stepping engine then pops it into the output register.
// Throughput: one input word per cycle while out_tready is high, set by the decision add and
// compare in the stepping engine; a two-entry queue lets front and back stall on their own.
// Reset: synchronous active-low rst_n empties the queue, clears the output valid flag and
// leaves the block idle with no line loaded.
`default_nettype none
module midpoint_line_rasterizer_unit #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // start_row, start_col, end_row, end_col, draw_color, zero pad
  input  wire logic [((4*COORD_BITS+8+7)/8)*8-1:0] in_tdata,
  // op
  input  wire logic                in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // pixel_row, pixel_col, pixel_color, zero pad
  output logic [((2*COORD_BITS+8+7)/8)*8-1:0] out_tdata,
  output logic                     out_tlast
);

  localparam int IN_W    = ((4*COORD_BITS+8+7)/8)*8;
  localparam int OUT_W   = ((2*COORD_BITS+8+7)/8)*8;
  localparam int ENTRY_W = 5*COORD_BITS + 11;
  localparam int Q_DEPTH = 2;

  logic [ENTRY_W-1:0] entry, q_data;
  logic               q_valid, q_pop, q_ready;

  assign in_tready = q_ready;

  mlr_front #(
    .COORD_BITS(COORD_BITS),
    .IN_W      (IN_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .entry   (entry)
  );

  mlr_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (entry),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  mlr_back #(
    .COORD_BITS(COORD_BITS),
    .ENTRY_W   (ENTRY_W),
    .OUT_W     (OUT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire
